// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, removable with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ----- src/gct_pkg.sv -----
// ----------------------------------------------------------------------------
// gct_pkg
// types and codes shared by the grow-only counter table
// ----------------------------------------------------------------------------
`default_nettype none
package gct_pkg;

	localparam logic [1:0] FN_NEW   = 2'd0;
	localparam logic [1:0] FN_ADD   = 2'd1;
	localparam logic [1:0] FN_MERGE = 2'd2;
	localparam logic [1:0] FN_READ  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [1:0] REG_DB  = 2'd0;
	localparam logic [1:0] REG_SYS = 2'd1;
	localparam logic [1:0] REG_TL  = 2'd2;

	typedef struct packed {
		logic [31:0] db;
		logic [63:0] sys;
		logic [31:0] tl;
	} key_t;

	typedef struct packed {
		logic [63:0] val;
		logic [31:0] ver;
	} ent_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [62:0] amount;
		key_t        rkey;
		logic [31:0] rver;
		logic [63:0] rval;
		logic [3:0]  idx;
	} cmd_t;

	typedef struct packed {
		logic [63:0] total;
		logic [4:0]  entry_count;
		logic [1:0]  status;
		key_t        key;
		ent_t        ent;
	} res_t;

endpackage
`default_nettype wire

// ----- src/gct_ram.sv -----
// ----------------------------------------------------------------------------
// gct_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module gct_ram #(
	parameter int W     = 64,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- src/gct_ctrl.sv -----
// ----------------------------------------------------------------------------
// gct_ctrl
// sequencer: key scan, read-modify-write of one entry, total and result word
// ----------------------------------------------------------------------------
`default_nettype none
module gct_ctrl
	import gct_pkg::*;
#(
	parameter int MAX_ENTRIES = 16,
	parameter int AW = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire key_t          loc_key,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire cmd_t          cmd,
	output logic               out_valid,
	input  wire logic          out_ready,
	output res_t               res,
	output logic               kwe,
	output logic               ewe,
	output logic [AW-1:0]      waddr,
	output key_t               wkey,
	output ent_t               went,
	output logic               re,
	output logic [AW-1:0]      raddr,
	input  wire key_t          rkey,
	input  wire ent_t          rent
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int XW = (CW > 4) ? CW : 4;

	typedef enum logic [2:0] {
		S_IDLE, S_DISPATCH, S_SCAN, S_CMP, S_UPD, S_RDW, S_RESP
	} state_t;

	state_t      state_q;
	cmd_t        cmd_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] ptr_q;
	logic [63:0] total_q;
	logic [63:0] delta_q;
	logic [1:0]  st_q;
	key_t        rdk_q;
	ent_t        rde_q;
	res_t        res_q;
	logic        out_valid_q;

	key_t        skey;
	logic [XW-1:0] idx_x;
	logic [XW-1:0] used_x;
	logic        in_range;
	logic        has_room;
	logic        match;
	ent_t        new_ent;
	logic [63:0] new_delta;
	logic [63:0] amt_x;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	assign amt_x    = {1'b0, cmd_q.amount};
	assign skey     = (cmd_q.func == FN_ADD) ? loc_key : cmd_q.rkey;
	assign idx_x    = XW'(cmd_q.idx);
	assign used_x   = XW'(used_q);
	assign in_range = (idx_x < used_x);
	assign has_room = (used_q < CW'(MAX_ENTRIES));
	assign match    = (rkey == skey);

	always_comb begin
		new_ent   = rent;
		new_delta = '0;
		if (cmd_q.func == FN_ADD) begin
			new_ent.val = rent.val + amt_x;
			new_ent.ver = rent.ver + 32'd1;
			new_delta   = amt_x;
		end else begin
			if (cmd_q.rver > rent.ver) begin
				new_ent.ver = cmd_q.rver;
			end
			if (cmd_q.rval > rent.val) begin
				new_ent.val = cmd_q.rval;
				new_delta   = cmd_q.rval - rent.val;
			end
		end
	end

	always_comb begin
		kwe   = 1'b0;
		ewe   = 1'b0;
		waddr = used_q[AW-1:0];
		wkey  = skey;
		went  = '{val: cmd_q.rval, ver: cmd_q.rver};
		re    = 1'b0;
		raddr = ptr_q[AW-1:0];
		case (state_q)
			S_DISPATCH: begin
				if (cmd_q.func == FN_NEW) begin
					kwe   = 1'b1;
					ewe   = 1'b1;
					waddr = '0;
					wkey  = loc_key;
					went  = '{val: amt_x, ver: 32'd1};
				end else if (cmd_q.func == FN_READ) begin
					re    = in_range;
					raddr = idx_x[AW-1:0];
				end
			end
			S_SCAN: begin
				if (ptr_q == used_q) begin
					kwe = has_room;
					ewe = has_room;
					if (cmd_q.func == FN_ADD) begin
						went = '{val: amt_x, ver: 32'd1};
					end
				end else begin
					re = 1'b1;
				end
			end
			S_CMP: begin
				ewe   = match;
				waddr = ptr_q[AW-1:0];
				went  = new_ent;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= cmd;
						st_q    <= ST_OK;
						rdk_q   <= '0;
						rde_q   <= '0;
						ptr_q   <= '0;
						delta_q <= '0;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (cmd_q.func)
						FN_NEW: begin
							used_q  <= CW'(1);
							total_q <= amt_x;
							state_q <= S_RESP;
						end
						FN_READ: begin
							if (in_range) begin
								state_q <= S_RDW;
							end else begin
								st_q    <= ST_RANGE;
								state_q <= S_RESP;
							end
						end
						default: begin
							state_q <= S_SCAN;
						end
					endcase
				end
				S_SCAN: begin
					if (ptr_q == used_q) begin
						if (has_room) begin
							used_q  <= used_q + CW'(1);
							delta_q <= (cmd_q.func == FN_ADD) ? amt_x : cmd_q.rval;
						end else begin
							st_q <= ST_FULL;
						end
						state_q <= S_UPD;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (match) begin
						delta_q <= new_delta;
						state_q <= S_UPD;
					end else begin
						ptr_q   <= ptr_q + CW'(1);
						state_q <= S_SCAN;
					end
				end
				S_UPD: begin
					total_q <= total_q + delta_q;
					state_q <= S_RESP;
				end
				S_RDW: begin
					rdk_q   <= rkey;
					rde_q   <= rent;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						res_q.total       <= total_q;
						res_q.entry_count <= 5'(used_q);
						res_q.status      <= st_q;
						res_q.key         <= rdk_q;
						res_q.ent         <= rde_q;
						out_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/grow_only_counter_table.sv -----
// ----------------------------------------------------------------------------
// grow_only_counter_table
// grow-only replicated counter: per-node entry table and running total
//
//   channel  signals                    direction
//   cfg      cfg_valid / cfg_ready      in, one register write per word
//   in       in_valid / in_ready        in, one command word
//   out      out_valid / out_ready      out, one result word per command
//
// new counter writes entry 0 at dispatch; read fetches the indexed entry through the
// registered memory read; add and merge scan the key memory one entry at a time
// (scan, then compare) and update on a match or append at the end if there is room.
// reset clears the entry count, total and local key; no clearing pass.
// a finished result sits in the output register while the next word is taken;
// the sequencer stalls only when a second result is ready before the first
// has left.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module grow_only_counter_table
	import gct_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [62:0] amount,
	input  wire logic [31:0] remote_db_id,
	input  wire logic [63:0] remote_system_id,
	input  wire logic [31:0] remote_timeline,
	input  wire logic [31:0] remote_version,
	input  wire logic [63:0] remote_value,
	input  wire logic [3:0]  entry_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      total,
	output logic [4:0]       entry_count,
	output logic [1:0]       status,
	output logic [31:0]      read_db_id,
	output logic [63:0]      read_system_id,
	output logic [31:0]      read_timeline,
	output logic [31:0]      read_version,
	output logic [63:0]      read_value
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	key_t loc_q;
	cmd_t cmd;
	res_t res;
	logic kwe, ewe, re;
	logic [AW-1:0] waddr, raddr;
	key_t wkey, rkey;
	ent_t went, rent;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loc_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DB:  loc_q.db  <= cfg_data[31:0];
				REG_SYS: loc_q.sys <= cfg_data;
				REG_TL:  loc_q.tl  <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	assign cmd = '{func: func, amount: amount,
		rkey: '{db: remote_db_id, sys: remote_system_id, tl: remote_timeline},
		rver: remote_version, rval: remote_value, idx: entry_index};

	gct_ctrl #(.MAX_ENTRIES(MAX_ENTRIES), .AW(AW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .loc_key(loc_q),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.out_valid(out_valid), .out_ready(out_ready), .res(res),
		.kwe(kwe), .ewe(ewe), .waddr(waddr), .wkey(wkey), .went(went),
		.re(re), .raddr(raddr), .rkey(rkey), .rent(rent)
	);

	gct_ram #(.W($bits(key_t)), .DEPTH(MAX_ENTRIES), .AW(AW)) u_key_ram (
		.clk(clk), .we(kwe), .waddr(waddr), .wdata(wkey),
		.re(re), .raddr(raddr), .rdata(rkey)
	);

	gct_ram #(.W($bits(ent_t)), .DEPTH(MAX_ENTRIES), .AW(AW)) u_ent_ram (
		.clk(clk), .we(ewe), .waddr(waddr), .wdata(went),
		.re(re), .raddr(raddr), .rdata(rent)
	);

	assign total          = res.total;
	assign entry_count    = res.entry_count;
	assign status         = res.status;
	assign read_db_id     = res.key.db;
	assign read_system_id = res.key.sys;
	assign read_timeline  = res.key.tl;
	assign read_version   = res.ent.ver;
	assign read_value     = res.ent.val;

	`ASSERT_PROP(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready)
	`ASSERT_PROP(a_range_zero, clk, arst_n, out_valid && status == ST_RANGE |-> read_value == 64'd0 && read_version == 32'd0)
	`ASSERT_PROP(a_full_count, clk, arst_n, out_valid && status == ST_FULL |-> entry_count == 5'(MAX_ENTRIES))
	`ASSERT_NEVER(a_read_on_write, clk, arst_n, re && (kwe || ewe))

endmodule
`default_nettype wire
